// ===== hdl/merge_insertion_hybrid_sorter_defines.svh =====
// Assertion macros used by the checker file mihs_checker.sv.
`ifndef MERGE_INSERTION_HYBRID_SORTER_DEFINES_SVH
`define MERGE_INSERTION_HYBRID_SORTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MIHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MIHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mihs_pkg.sv =====
package mihs_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned VALUE_W      = 31;
  localparam int unsigned TDATA_W      = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_EREAD,
    ST_EWAIT,
    ST_EHOLD
  } state_t;

endpackage

// ===== hdl/mihs_ram.sv =====
module mihs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/merge_insertion_hybrid_sorter.sv =====
// Collects a set of values and returns it in ascending order once the
// transaction marked by in_tlast is taken. Each value is inserted into a
// sorted single-port-write RAM on arrival: every stored value greater than
// it is moved up one slot, each in turn, and the value is written into the
// freed slot. The first value of a set is written directly, and a value
// arriving while the RAM already holds CAPACITY values is dropped.
// Results are read back from the same RAM one at a time through ST_EREAD,
// ST_EWAIT and ST_EHOLD, the next only after the previous one is taken;
// out_tlast marks the last one and out_tuser flags a set in which values
// beyond CAPACITY were dropped. The input is not taken while a set is being emitted.
module merge_insertion_hybrid_sorter #(
  parameter int unsigned CAPACITY = mihs_pkg::CAPACITY_DEF,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] value, [31] zero fill
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [30:0] sorted_value, [31] zero fill
  output logic        out_tlast,
  output logic        out_tuser   // [0] overflow
);

  localparam int unsigned VW = mihs_pkg::VALUE_W;

  mihs_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic          setlast_r, setlast_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [VW-1:0] key_r, key_nxt;
  logic [AW-1:0] e_r, e_nxt;
  logic [VW-1:0] odata_r, odata_nxt;
  logic          olast_r, olast_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [VW-1:0] wr_data, rd_data;
  logic          in_acc;

  mihs_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign in_tready  = (state_r == mihs_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == mihs_pkg::ST_EHOLD);
  assign out_tdata  = {1'b0, odata_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = drop_r;

  // Insertion walk, readback and output sequencing.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    drop_nxt    = drop_r;
    setlast_nxt = setlast_r;
    j_nxt       = j_r;
    key_nxt     = key_r;
    e_nxt       = e_r;
    odata_nxt   = odata_r;
    olast_nxt   = olast_r;
    wr_en       = 1'b0;
    wr_addr     = j_r + AW'(1);
    wr_data     = key_r;
    rd_addr     = j_r;
    unique case (state_r)
      mihs_pkg::ST_IDLE: begin
        e_nxt = '0;
        if (in_acc) begin
          setlast_nxt = in_tlast;
          key_nxt     = in_tdata[VW-1:0];
          if (count_r == CW'(CAPACITY)) begin
            drop_nxt = 1'b1;
            if (in_tlast) state_nxt = mihs_pkg::ST_EREAD;
          end else if (count_r == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = in_tdata[VW-1:0];
            count_nxt = CW'(1);
            if (in_tlast) state_nxt = mihs_pkg::ST_EREAD;
          end else begin
            rd_addr   = AW'(count_r - CW'(1));
            j_nxt     = AW'(count_r - CW'(1));
            state_nxt = mihs_pkg::ST_SHIFT;
          end
        end
      end
      mihs_pkg::ST_SHIFT: begin
        wr_en = 1'b1;
        if (rd_data > key_r) begin
          // Move the larger value up one slot and look further down.
          wr_data = rd_data;
          if (j_r == '0) begin
            state_nxt = mihs_pkg::ST_PLACE;
          end else begin
            rd_addr = j_r - AW'(1);
            j_nxt   = j_r - AW'(1);
          end
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = setlast_r ? mihs_pkg::ST_EREAD : mihs_pkg::ST_IDLE;
        end
      end
      mihs_pkg::ST_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        count_nxt = count_r + CW'(1);
        state_nxt = setlast_r ? mihs_pkg::ST_EREAD : mihs_pkg::ST_IDLE;
      end
      mihs_pkg::ST_EREAD: begin
        rd_addr   = e_r;
        state_nxt = mihs_pkg::ST_EWAIT;
      end
      mihs_pkg::ST_EWAIT: begin
        odata_nxt = rd_data;
        olast_nxt = (CW'(e_r) == count_r - CW'(1));
        state_nxt = mihs_pkg::ST_EHOLD;
      end
      mihs_pkg::ST_EHOLD: begin
        if (out_tready) begin
          if (olast_r) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = mihs_pkg::ST_IDLE;
          end else begin
            e_nxt     = e_r + AW'(1);
            state_nxt = mihs_pkg::ST_EREAD;
          end
        end
      end
      default: state_nxt = mihs_pkg::ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mihs_pkg::ST_IDLE;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    setlast_r <= setlast_nxt;
    j_r       <= j_nxt;
    key_r     <= key_nxt;
    e_r       <= e_nxt;
    odata_r   <= odata_nxt;
    olast_r   <= olast_nxt;
  end

endmodule

// ===== hdl/mihs_checker.sv =====
`include "merge_insertion_hybrid_sorter_defines.svh"

module mihs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  logic [30:0] prev_r;
  logic        mid_set_r;

  // Remember the last value taken while a set is still being emitted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      mid_set_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      prev_r    <= out_tdata[30:0];
      mid_set_r <= !out_tlast;
    end
  end

  // A stalled result stays offered.
  `MIHS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped")

  // A stalled result keeps its contents.
  `MIHS_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // Input is never taken while a result is on offer.
  `MIHS_ASSERT(a_no_overlap, !(in_tready && out_tvalid), "input taken during output")

  // Nothing is offered right after reset.
  `MIHS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "output after reset")

  // Results within a set come out in ascending order.
  `MIHS_ASSERT(a_ascending, out_tvalid && out_tready && mid_set_r |-> out_tdata[30:0] >= prev_r, "results out of order")

endmodule

bind merge_insertion_hybrid_sorter mihs_checker u_mihs_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

// ===== bench/merge_insertion_hybrid_sorter_checker.sv =====
`timescale 1ns / 1ps

module merge_insertion_hybrid_sorter_checker #(
  parameter int unsigned CAPACITY = mihs_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [mihs_pkg::VALUE_W-1:0] value;
    logic                         last;
    logic                         overflow;
  } sorted_item_t;

  logic [mihs_pkg::VALUE_W-1:0] held_values[$];
  logic                         dropped;
  sorted_item_t                 sorted_queue[$];

  // Collect the set and, when the last transaction arrives, queue it in order.
  task automatic collect_value(input logic [mihs_pkg::VALUE_W-1:0] v, input logic is_last);
    logic [mihs_pkg::VALUE_W-1:0] ordered[$];
    sorted_item_t item;
    if (held_values.size() < CAPACITY) held_values.insert(held_values.size(), v);
    else dropped = 1'b1;
    if (is_last) begin
      ordered = held_values;
      ordered.sort();
      foreach (ordered[k]) begin
        item.value    = ordered[k];
        item.last     = (k == ordered.size() - 1);
        item.overflow = dropped;
        sorted_queue.insert(sorted_queue.size(), item);
      end
      held_values.delete();
      dropped = 1'b0;
    end
  endtask

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    sorted_item_t want;
    if (!rst_n) begin
      held_values.delete();
      sorted_queue.delete();
      dropped    = 1'b0;
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sorted_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: value=%0d last=%0b ovf=%0b",
                     out_tdata[mihs_pkg::VALUE_W-1:0], out_tlast, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = sorted_queue.pop_front();
          if (out_tdata !== {1'b0, want.value} || out_tlast !== want.last ||
              out_tuser !== want.overflow) begin
            if (fail_count < 10)
              $display("mismatch: expected value=%0d last=%0b ovf=%0b, got %0d %0b %0b",
                       want.value, want.last, want.overflow,
                       out_tdata, out_tlast, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        collect_value(in_tdata[mihs_pkg::VALUE_W-1:0], in_tlast);
    end
    pending_count <= sorted_queue.size();
  end
endmodule

// ===== bench/merge_insertion_hybrid_sorter_tb.sv =====
`timescale 1ns / 1ps

module merge_insertion_hybrid_sorter_tb;

  localparam int unsigned CAP = mihs_pkg::CAPACITY_DEF;
  localparam longint CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  longint      cycle_count;

  merge_insertion_hybrid_sorter #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  merge_insertion_hybrid_sorter_checker #(.CAPACITY(CAP)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("merge_insertion_hybrid_sorter_tb NOT OK");
      $finish;
    end
  end

  // Present one transaction, with a random idle gap first, and hold it until taken.
  task automatic send_value(input logic [30:0] v, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, v};
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_set(input int unsigned n);
    for (int unsigned k = 0; k < n; k++)
      send_value(($urandom_range(3) == 0) ? 31'($urandom_range(7)) : 31'($urandom),
                 k == n - 1);
  endtask

  // Let the checker see the last transaction, then wait for every result.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    int phase;
    cycle_count    = 0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets: single value, extremes, zero, duplicates, descending.
    send_value(31'h7FFFFFFF, 1'b1);
    send_value(31'd0, 1'b1);
    send_value(31'h7FFFFFFF, 1'b0);
    send_value(31'd1, 1'b0);
    send_value(31'd0, 1'b0);
    send_value(31'h55555555, 1'b0);
    send_value(31'h2AAAAAAA, 1'b0);
    send_value(31'd1, 1'b1);
    for (int k = 8; k > 0; k--) send_value(31'(k), k == 1);
    for (int k = 0; k < 6; k++) send_value(31'd5, k == 5);
    // Pause until everything has come out.
    drain_results();

    // Full store and overflow, including a dropped last element.
    for (int k = 0; k < CAP; k++) send_value(31'($urandom), k == CAP - 1);
    for (int k = 0; k < CAP + 3; k++) send_value(31'($urandom), k == CAP + 2);
    drain_results();

    // Random sets across the idling phases, mostly small.
    for (int s = 0; s < 28; s++) begin
      phase = s / 7;
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 59 : 27) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 59 : 27) : 0;
      n = ($urandom_range(9) == 0) ? $urandom_range(CAP + 4, CAP - 2)
                                   : $urandom_range(12, 1);
      send_set(n);
    end

    drain_results();
    repeat (500) @(posedge clk);
    if (fail_count == 0) begin
      $display("merge_insertion_hybrid_sorter_tb OK");
    end else begin
      $display("merge_insertion_hybrid_sorter_tb NOT OK");
    end
    $finish;
  end
endmodule
